// ----- hdl/ltem_pkg.sv -----
// Package for the linear triangle element matrix unit.
// Holds widths, the queue entry and pipeline tag types, entry order and saturation helpers.
// No dependencies.
package ltem_pkg;

  localparam int CW = 18;            // coordinate width, Q5.12
  localparam int PW = 16;            // parameter width, Q7.8
  localparam int DW = 19;            // edge difference width
  localparam int AW = 39;            // |det| width
  localparam int DVD_W = 55;         // divider dividend width
  localparam int QB = 33;            // quotient bits produced by the divider
  localparam int REM_W = 40;         // divider remainder width
  localparam int NLANE = 1;          // divider lanes: stiffness only
  localparam int QDEPTH = 4;         // triangle queue depth
  localparam int WW = 20;            // weighted parameter sum width

  localparam int LANE_STIFF = 0;

  localparam logic [2:0] LAST_K = 3'd5;
  localparam logic [21:0] PM_HALF = 22'd3932160;
  localparam int PM_SHIFT = 19;

  // Reciprocal multiplication for the constant divisors 3 and 15.
  localparam logic [31:0] MASS_RECIP = 32'hAAAA_AAAB;
  localparam int MASS_RSH = 33;
  localparam logic [31:0] PM_RECIP = 32'h8888_8889;
  localparam int PM_RSH = 35;
  localparam int PM_SPLIT = 18;
  // Shifted weighted product at or above this gives a quotient beyond 2^31.
  localparam logic [39:0] PM_SAT_Y = 40'd32212254735;

  typedef struct packed {
    logic [2:0][DW-1:0] b;
    logic [2:0][DW-1:0] c;
    logic [2:0][PW-1:0] p;
    logic [AW-1:0]      adet;
    logic               degen;
  } tri_t;

  typedef struct packed {
    logic       valid;
    logic [1:0] row;
    logic [1:0] col;
    logic       last;
    logic       degen;
    logic       sneg;
    logic       pneg;
  } tag_t;

  function automatic logic [1:0] entry_row(input logic [2:0] k);
    logic [1:0] r;
    case (k)
      3'd0: r = 2'd0;
      3'd1: r = 2'd1;
      3'd2: r = 2'd2;
      3'd3: r = 2'd1;
      3'd4: r = 2'd2;
      default: r = 2'd2;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] entry_col(input logic [2:0] k);
    logic [1:0] r;
    case (k)
      3'd0, 3'd1, 3'd2: r = 2'd0;
      3'd3, 3'd4: r = 2'd1;
      default: r = 2'd2;
    endcase
    return r;
  endfunction

  // Apply sign and clamp a rounded magnitude to the signed 32-bit range.
  function automatic logic [31:0] sat32(input logic [QB-1:0] q, input logic ovf,
                                        input logic neg);
    logic [31:0] r;
    if (neg) begin
      if (ovf || (q > QB'(33'h0_8000_0000))) r = 32'h8000_0000;
      else r = 32'd0 - q[31:0];
    end else begin
      if (ovf || (q > QB'(33'h0_7FFF_FFFF))) r = 32'h7FFF_FFFF;
      else r = q[31:0];
    end
    return r;
  endfunction

endpackage

// ----- hdl/ltem_in_if.sv -----
// Input channel of the triangle element matrix unit: one triangle per transfer.
// Depends on ltem_pkg.
interface ltem_in_if;
  logic valid;
  logic ready;
  logic signed [ltem_pkg::CW-1:0] x0;
  logic signed [ltem_pkg::CW-1:0] y0;
  logic signed [ltem_pkg::CW-1:0] x1;
  logic signed [ltem_pkg::CW-1:0] y1;
  logic signed [ltem_pkg::CW-1:0] x2;
  logic signed [ltem_pkg::CW-1:0] y2;
  logic signed [ltem_pkg::PW-1:0] p0;
  logic signed [ltem_pkg::PW-1:0] p1;
  logic signed [ltem_pkg::PW-1:0] p2;

  modport source(output valid, x0, y0, x1, y1, x2, y2, p0, p1, p2, input ready);
  modport sink(input valid, x0, y0, x1, y1, x2, y2, p0, p1, p2, output ready);
endinterface

// ----- hdl/ltem_out_if.sv -----
// Output channel of the triangle element matrix unit: one matrix entry per transfer.
// Standalone.
interface ltem_out_if;
  logic valid;
  logic ready;
  logic [1:0] row;
  logic [1:0] col;
  logic signed [31:0] stiffness;
  logic [30:0] mass;
  logic signed [31:0] param_mass;
  logic degenerate;
  logic last;

  modport source(output valid, row, col, stiffness, mass, param_mass, degenerate, last,
                 input ready);
  modport sink(input valid, row, col, stiffness, mass, param_mass, degenerate, last,
               output ready);
endinterface

// ----- hdl/ltem_front.sv -----
// Front part: accepts triangles, forms edge differences and the doubled area.
// Depends on ltem_pkg and ltem_in_if.
module ltem_front (
  input  logic             clk,
  input  logic             rst,
  ltem_in_if.sink          req,
  output ltem_pkg::tri_t   push_data,
  output logic             push_valid,
  input  logic             push_ready
);

  logic en;
  logic v1, v2, v3;
  logic [2:0][ltem_pkg::DW-1:0] s1_b, s1_c, s2_b, s2_c;
  logic [2:0][ltem_pkg::PW-1:0] s1_p, s2_p;
  logic signed [2*ltem_pkg::DW-1:0] s2_pa, s2_pb;
  ltem_pkg::tri_t s3;
  logic signed [ltem_pkg::AW-1:0] det;

  assign en = !v3 || push_ready;
  assign req.ready = en;
  assign push_valid = v3;
  assign push_data = s3;

  assign det = ltem_pkg::AW'(s2_pa) - ltem_pkg::AW'(s2_pb);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (en) begin
      v1 <= req.valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_b[0] <= ltem_pkg::DW'(req.y1) - ltem_pkg::DW'(req.y2);
      s1_b[1] <= ltem_pkg::DW'(req.y2) - ltem_pkg::DW'(req.y0);
      s1_b[2] <= ltem_pkg::DW'(req.y0) - ltem_pkg::DW'(req.y1);
      s1_c[0] <= ltem_pkg::DW'(req.x2) - ltem_pkg::DW'(req.x1);
      s1_c[1] <= ltem_pkg::DW'(req.x0) - ltem_pkg::DW'(req.x2);
      s1_c[2] <= ltem_pkg::DW'(req.x1) - ltem_pkg::DW'(req.x0);
      s1_p[0] <= req.p0;
      s1_p[1] <= req.p1;
      s1_p[2] <= req.p2;
      // det = c2*b1 - b2*c1
      s2_pa <= $signed(s1_c[2]) * $signed(s1_b[1]);
      s2_pb <= $signed(s1_b[2]) * $signed(s1_c[1]);
      s2_b <= s1_b;
      s2_c <= s1_c;
      s2_p <= s1_p;
      s3.b <= s2_b;
      s3.c <= s2_c;
      s3.p <= s2_p;
      s3.adet <= det[ltem_pkg::AW-1] ? ltem_pkg::AW'(-det) : ltem_pkg::AW'(det);
      s3.degen <= (det == '0);
    end
  end

endmodule

// ----- hdl/ltem_fifo.sv -----
// Short triangle queue between front and back parts.
// Depends on ltem_pkg.
module ltem_fifo #(
  parameter int DEPTH = ltem_pkg::QDEPTH
) (
  input  logic           clk,
  input  logic           rst,
  input  ltem_pkg::tri_t push_data,
  input  logic           push_valid,
  output logic           push_ready,
  output ltem_pkg::tri_t pop_data,
  output logic           pop_valid,
  input  logic           pop
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  ltem_pkg::tri_t mem [DEPTH];
  logic [PTR_W-1:0] wptr, rptr;
  logic [PTR_W:0] count;
  logic do_push, do_pop;

  assign push_ready = (count != (PTR_W+1)'(DEPTH));
  assign pop_valid = (count != '0);
  assign pop_data = mem[rptr];
  assign do_push = push_valid && push_ready;
  assign do_pop = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      count <= '0;
    end else begin
      if (do_push) wptr <= (wptr == PTR_W'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      if (do_pop) rptr <= (rptr == PTR_W'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      if (do_push && !do_pop) count <= count + 1'b1;
      else if (!do_push && do_pop) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem[wptr] <= push_data;
  end

endmodule

// ----- hdl/ltem_div.sv -----
// Pipelined restoring divider for the stiffness quotient, one quotient bit per stage.
// Depends on ltem_pkg.
module ltem_div (
  input  logic                                        clk,
  input  logic                                        rst,
  input  logic                                        en,
  input  ltem_pkg::tag_t                              in_tag,
  input  logic [ltem_pkg::NLANE-1:0][ltem_pkg::DVD_W-1:0] in_dvd,
  input  logic [ltem_pkg::NLANE-1:0][ltem_pkg::AW-1:0]    in_den,
  output ltem_pkg::tag_t                              out_tag,
  output logic [ltem_pkg::NLANE-1:0][ltem_pkg::QB-1:0]    out_q,
  output logic [ltem_pkg::NLANE-1:0]                  out_ovf
);

  localparam int NS = ltem_pkg::QB + 1;

  ltem_pkg::tag_t s_tag [NS];
  logic [ltem_pkg::NLANE-1:0][ltem_pkg::REM_W-1:0] s_rem [NS];
  logic [ltem_pkg::NLANE-1:0][ltem_pkg::QB-1:0]    s_low [NS];
  logic [ltem_pkg::NLANE-1:0][ltem_pkg::QB-1:0]    s_q [NS];
  logic [ltem_pkg::NLANE-1:0][ltem_pkg::AW-1:0]    s_den [NS];
  logic [ltem_pkg::NLANE-1:0]                      s_ovf [NS];

  // Entry stage: flag quotients of 2^QB or more, load the top dividend bits.
  always_ff @(posedge clk) begin
    if (rst) s_tag[0] <= '0;
    else if (en) s_tag[0] <= in_tag;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < ltem_pkg::NLANE; l++) begin
        s_ovf[0][l] <= ltem_pkg::REM_W'(in_dvd[l][ltem_pkg::DVD_W-1:ltem_pkg::QB])
                       >= ltem_pkg::REM_W'(in_den[l]);
        s_rem[0][l] <= ltem_pkg::REM_W'(in_dvd[l][ltem_pkg::DVD_W-1:ltem_pkg::QB]);
        s_low[0][l] <= in_dvd[l][ltem_pkg::QB-1:0];
        s_q[0][l] <= '0;
        s_den[0][l] <= in_den[l];
      end
    end
  end

  for (genvar s = 1; s < NS; s++) begin : g_stage
    logic [ltem_pkg::NLANE-1:0][ltem_pkg::REM_W-1:0] trial;
    logic [ltem_pkg::NLANE-1:0] ge;

    always_comb begin
      for (int l = 0; l < ltem_pkg::NLANE; l++) begin
        trial[l] = {s_rem[s-1][l][ltem_pkg::REM_W-2:0], s_low[s-1][l][ltem_pkg::QB-1]};
        ge[l] = trial[l] >= ltem_pkg::REM_W'(s_den[s-1][l]);
      end
    end

    always_ff @(posedge clk) begin
      if (rst) s_tag[s] <= '0;
      else if (en) s_tag[s] <= s_tag[s-1];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        for (int l = 0; l < ltem_pkg::NLANE; l++) begin
          s_rem[s][l] <= ge[l] ? trial[l] - ltem_pkg::REM_W'(s_den[s-1][l]) : trial[l];
          s_low[s][l] <= {s_low[s-1][l][ltem_pkg::QB-2:0], 1'b0};
          s_q[s][l] <= {s_q[s-1][l][ltem_pkg::QB-2:0], ge[l]};
          s_den[s][l] <= s_den[s-1][l];
        end
        s_ovf[s] <= s_ovf[s-1];
      end
    end
  end

  assign out_tag = s_tag[NS-1];
  assign out_q = s_q[NS-1];
  assign out_ovf = s_ovf[NS-1];

endmodule

// ----- hdl/ltem_back.sv -----
// Back part: walks the six entries of each queued triangle, forms numerators,
// divides and saturates into the output register. Depends on ltem_pkg, ltem_div, ltem_out_if.
module ltem_back (
  input  logic           clk,
  input  logic           rst,
  input  ltem_pkg::tri_t hd,
  input  logic           hv,
  output logic           pop,
  ltem_out_if.source     rsp
);

  localparam int DLY = ltem_pkg::QB - 1;

  logic adv;
  logic [2:0] k;
  logic [1:0] ar, ac;
  logic signed [17:0] psum;
  logic signed [ltem_pkg::WW-1:0] wsum;
  logic signed [ltem_pkg::PW-1:0] pi, pj;

  ltem_pkg::tag_t a_tag, b_tag, c_tag, d_tag;
  logic signed [2*ltem_pkg::DW-1:0] a_bb, a_cc;
  logic [ltem_pkg::WW-1:0] a_wmag;
  logic [ltem_pkg::AW-1:0] a_adet, b_adet, c_adet;
  logic signed [2*ltem_pkg::DW:0] num;
  logic [2*ltem_pkg::DW:0] nmag;
  logic [ltem_pkg::DVD_W-1:0] b_nd;
  logic [31:0] b_md;
  logic [39:0] b_plo;
  logic [38:0] b_phi;
  logic [58:0] pd_sum;
  logic [39:0] mass_sum;
  logic [ltem_pkg::NLANE-1:0][ltem_pkg::DVD_W-1:0] c_dvd;
  logic [ltem_pkg::NLANE-1:0][ltem_pkg::AW-1:0] c_den;
  logic [ltem_pkg::NLANE-1:0][ltem_pkg::QB-1:0] d_q;
  logic [ltem_pkg::NLANE-1:0] d_ovf;

  logic [31:0] c_mx;
  logic [39:0] c_py;
  logic [63:0] m_prod, qh_prod, qz_prod;
  logic [16:0] yh, qh, qh15;
  logic [21:0] z;
  logic [30:0] e_mass, f_mass;
  logic [16:0] e_qh;
  logic [3:0] e_rh;
  logic [17:0] e_yl;
  logic e_povf, f_povf;
  logic [ltem_pkg::QB-1:0] f_pq;
  logic [30:0] dl_mass [DLY];
  logic [ltem_pkg::QB-1:0] dl_pq [DLY];
  logic dl_povf [DLY];

  logic ov;
  logic [1:0] o_row, o_col;
  logic [31:0] o_stiff, o_pm;
  logic [30:0] o_mass;
  logic o_degen, o_last;

  // The whole back pipeline moves when the output register is free or draining.
  assign adv = !ov || rsp.ready;
  assign pop = adv && hv && (k == ltem_pkg::LAST_K);

  assign ar = ltem_pkg::entry_row(k);
  assign ac = ltem_pkg::entry_col(k);
  assign pi = $signed(hd.p[ar]);
  assign pj = $signed(hd.p[ac]);
  assign psum = 18'($signed(hd.p[0])) + 18'($signed(hd.p[1])) + 18'($signed(hd.p[2]));

  always_comb begin
    if (ar == ac) wsum = (ltem_pkg::WW'(psum) <<< 1) + (ltem_pkg::WW'(pi) <<< 2);
    else wsum = ltem_pkg::WW'(psum) + ltem_pkg::WW'(pi) + ltem_pkg::WW'(pj);
  end

  always_ff @(posedge clk) begin
    if (rst) k <= '0;
    else if (adv && hv) k <= (k == ltem_pkg::LAST_K) ? '0 : k + 1'b1;
  end

  // Stage A: products of edge terms, parameter weight.
  always_ff @(posedge clk) begin
    if (rst) a_tag <= '0;
    else if (adv) begin
      a_tag.valid <= hv;
      a_tag.row <= ar;
      a_tag.col <= ac;
      a_tag.last <= (k == ltem_pkg::LAST_K);
      a_tag.degen <= hd.degen;
      a_tag.sneg <= 1'b0;
      a_tag.pneg <= wsum[ltem_pkg::WW-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_bb <= $signed(hd.b[ar]) * $signed(hd.b[ac]);
      a_cc <= $signed(hd.c[ar]) * $signed(hd.c[ac]);
      a_wmag <= wsum[ltem_pkg::WW-1] ? ltem_pkg::WW'(-wsum) : ltem_pkg::WW'(wsum);
      a_adet <= hd.adet;
    end
  end

  // Stage B: stiffness dividend, split weighted product, mass dividend.
  assign num = (2*ltem_pkg::DW+1)'(a_bb) + (2*ltem_pkg::DW+1)'(a_cc);
  assign nmag = num[2*ltem_pkg::DW] ? (2*ltem_pkg::DW+1)'(-num) : (2*ltem_pkg::DW+1)'(num);
  assign mass_sum = (a_tag.row == a_tag.col) ? 40'(a_adet) + 40'd1536 : 40'(a_adet) + 40'd3072;

  always_ff @(posedge clk) begin
    if (rst) b_tag <= '0;
    else if (adv) b_tag <= {a_tag.valid, a_tag.row, a_tag.col, a_tag.last, a_tag.degen,
                            num[2*ltem_pkg::DW], a_tag.pneg};
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_nd <= (ltem_pkg::DVD_W'(nmag) << 15) + ltem_pkg::DVD_W'(a_adet >> 1);
      b_plo <= a_adet[19:0] * a_wmag;
      b_phi <= a_adet[ltem_pkg::AW-1:20] * a_wmag;
      b_md <= (a_tag.row == a_tag.col) ? 32'(mass_sum >> 10) : 32'(mass_sum >> 11);
      b_adet <= a_adet;
    end
  end

  // Stage C: join the weighted product, round, drop the power-of-two part.
  assign pd_sum = (59'(b_phi) << 20) + 59'(b_plo) + 59'(ltem_pkg::PM_HALF);

  always_ff @(posedge clk) begin
    if (rst) c_tag <= '0;
    else if (adv) c_tag <= b_tag;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_dvd[ltem_pkg::LANE_STIFF] <= b_nd;
      c_mx <= b_md;
      c_py <= pd_sum[58:ltem_pkg::PM_SHIFT];
      c_adet <= b_adet;
    end
  end

  assign c_den[ltem_pkg::LANE_STIFF] = c_adet;

  ltem_div u_div (
    .clk    (clk),
    .rst    (rst),
    .en     (adv),
    .in_tag (c_tag),
    .in_dvd (c_dvd),
    .in_den (c_den),
    .out_tag(d_tag),
    .out_q  (d_q),
    .out_ovf(d_ovf)
  );

  // Constant divisors beside the divider: mass by 3, weighted mass by 15 in two halves.
  assign m_prod = 64'(c_mx) * 64'(ltem_pkg::MASS_RECIP);
  assign yh = c_py[34:ltem_pkg::PM_SPLIT];
  assign qh_prod = 64'(yh) * 64'(ltem_pkg::PM_RECIP);
  assign qh = 17'(qh_prod >> ltem_pkg::PM_RSH);
  assign qh15 = (qh << 4) - qh;

  always_ff @(posedge clk) begin
    if (adv) begin
      e_mass <= 31'(m_prod >> ltem_pkg::MASS_RSH);
      e_qh <= qh;
      e_rh <= 4'(yh - qh15);
      e_yl <= c_py[ltem_pkg::PM_SPLIT-1:0];
      e_povf <= (c_py >= ltem_pkg::PM_SAT_Y);
    end
  end

  assign z = {e_rh, e_yl};
  assign qz_prod = 64'(z) * 64'(ltem_pkg::PM_RECIP);

  always_ff @(posedge clk) begin
    if (adv) begin
      f_mass <= e_mass;
      f_pq <= (ltem_pkg::QB'(e_qh) << ltem_pkg::PM_SPLIT) +
              ltem_pkg::QB'(qz_prod >> ltem_pkg::PM_RSH);
      f_povf <= e_povf;
    end
  end

  // Delay the constant quotients to line up with the divider output.
  always_ff @(posedge clk) begin
    if (adv) begin
      dl_mass[0] <= f_mass;
      dl_pq[0] <= f_pq;
      dl_povf[0] <= f_povf;
      for (int i = 1; i < DLY; i++) begin
        dl_mass[i] <= dl_mass[i-1];
        dl_pq[i] <= dl_pq[i-1];
        dl_povf[i] <= dl_povf[i-1];
      end
    end
  end

  // Output register: sign, saturate, hold until the transfer.
  always_ff @(posedge clk) begin
    if (rst) ov <= 1'b0;
    else if (adv) ov <= d_tag.valid;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      o_row <= d_tag.row;
      o_col <= d_tag.col;
      o_last <= d_tag.last;
      o_degen <= d_tag.degen;
      o_stiff <= d_tag.degen ? 32'd0
               : ltem_pkg::sat32(d_q[ltem_pkg::LANE_STIFF], d_ovf[ltem_pkg::LANE_STIFF],
                                 d_tag.sneg);
      o_pm <= ltem_pkg::sat32(dl_pq[DLY-1], dl_povf[DLY-1], d_tag.pneg);
      o_mass <= dl_mass[DLY-1];
    end
  end

  assign rsp.valid = ov;
  assign rsp.row = o_row;
  assign rsp.col = o_col;
  assign rsp.stiffness = o_stiff;
  assign rsp.mass = o_mass;
  assign rsp.param_mass = o_pm;
  assign rsp.degenerate = o_degen;
  assign rsp.last = o_last;

endmodule

// ----- hdl/linear_triangle_element_matrices_unit.sv -----
// Linear triangle element matrices: one triangle in, six lower-triangle entries out.
// Pipeline from triangle transfer to first entry: 3 front stages, queue, 3 operand stages,
// 34 divider stages, output register. Throughput: one entry per cycle while the result
// channel accepts, so each triangle leaves as six transfers on the single result channel.
// Reset (rst, synchronous): empties the queue and clears all valid flags and the entry counter.
module linear_triangle_element_matrices_unit #(
  parameter int QUEUE_DEPTH = ltem_pkg::QDEPTH
) (
  input  logic        clk,
  input  logic        rst,
  ltem_in_if.sink     req,
  ltem_out_if.source  rsp
);

  // Front to queue.
  ltem_pkg::tri_t push_data;
  logic push_valid, push_ready;

  // Queue to back; the back part pops a triangle after issuing its sixth entry.
  ltem_pkg::tri_t head;
  logic head_valid, pop;

  // Accept triangles and compute edge terms and |det|; stall only on a full queue.
  ltem_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .push_data (push_data),
    .push_valid(push_valid),
    .push_ready(push_ready)
  );

  // Decouple the two parts so a stalled result channel does not block intake at once.
  ltem_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push_data (push_data),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .pop_data  (head),
    .pop_valid (head_valid),
    .pop       (pop)
  );

  // Expand each triangle into its six entries, divide, saturate, transfer.
  ltem_back u_back (
    .clk(clk),
    .rst(rst),
    .hd (head),
    .hv (head_valid),
    .pop(pop),
    .rsp(rsp)
  );

  // The run always ends on the bottom-right diagonal entry.
  a_last_corner: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.last |-> (rsp.row == 2'd2) && (rsp.col == 2'd2))
    else $error("last entry not at (2,2)");

  // A zero-area triangle gives zero stiffness.
  a_degen_stiff: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.degenerate |-> rsp.stiffness == 32'sd0)
    else $error("degenerate entry with nonzero stiffness");

  // Only lower-triangle entries leave the unit.
  a_lower: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> rsp.col <= rsp.row)
    else $error("entry above the diagonal");

endmodule
